// ----- rtl/core/mwo_pkg.sv -----
package mwo_pkg;

    // fixed widths of the phase and sample paths
    localparam int PHASE_BITS       = 32;
    localparam int SAMPLE_BITS      = 16;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int ROM_ADDR_BITS    = $clog2(SINE_TABLE_DEPTH);
    localparam int MAX_BLOCK_LOG2   = 12;
    localparam int INDEX_BITS       = MAX_BLOCK_LOG2 + 1;
    localparam int DIFF_BITS        = PHASE_BITS + 1;
    localparam int RAMP_BITS        = DIFF_BITS + MAX_BLOCK_LOG2 + 1;
    localparam int APB_ADDR_BITS    = 5;
    localparam int APB_DATA_BITS    = 32;

    typedef logic [PHASE_BITS-1:0]        phase_t;
    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [2:0]                   wave_t;
    typedef logic [2:0]                   reg_idx_t;
    typedef logic [SAMPLE_BITS-1:0]       sine_rom_t [SINE_TABLE_DEPTH];

    // waveform codes
    localparam wave_t WAVE_SINE      = 3'd0;
    localparam wave_t WAVE_SQUARE    = 3'd1;
    localparam wave_t WAVE_TRIANGLE  = 3'd2;
    localparam wave_t WAVE_RISE_SAW  = 3'd3;
    localparam wave_t WAVE_FALL_SAW  = 3'd4;

    // register indexes (byte address / 4)
    localparam reg_idx_t REG_WAVEFORM        = 3'd0;
    localparam reg_idx_t REG_PHASE_INCREMENT = 3'd1;
    localparam reg_idx_t REG_PHASE_SHIFT     = 3'd2;
    localparam reg_idx_t REG_USE_EXTERNAL    = 3'd3;
    localparam reg_idx_t REG_BLOCK_LEN_LOG2  = 3'd4;

    localparam logic [3:0] BLOCK_LEN_LOG2_RESET = 4'd9;
    localparam logic [INDEX_BITS-1:0] INDEX_MAX = INDEX_BITS'(1) << MAX_BLOCK_LOG2;

    localparam sample_t SAMPLE_POS_MAX = sample_t'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam sample_t SAMPLE_NEG_MAX = sample_t'(1 << (SAMPLE_BITS - 1));

    // q30 constants for the quarter-wave table build
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint          ROM_SCALE   = 64'd32767;
    localparam longint unsigned TAYLOR_DIV [1:12] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
    };

    // quarter-wave sine, rounded q1.15, built with a q30 taylor series
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t       rom;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          s;
        longint          r;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++)
        begin
            x    = (HALF_PI_Q30 * longint'(k)) / SINE_TABLE_DEPTH;
            x2   = (x * x) >> 30;
            term = x;
            s    = longint'(x);
            for (int n = 1; n <= 12; n++)
            begin
                term = ((term * x2) >> 30) / TAYLOR_DIV[n];
                if ((n % 2) == 1)
                    s = s - longint'(term);
                else
                    s = s + longint'(term);
            end
            if (s < 0)
                s = 0;
            r = (s * ROM_SCALE + (longint'(1) << 29)) >>> 30;
            if (r > ROM_SCALE)
                r = ROM_SCALE;
            rom[k] = SAMPLE_BITS'(r);
        end
        return rom;
    endfunction

endpackage

// ----- rtl/core/mwo_in_if.sv -----
interface mwo_in_if import mwo_pkg::*; ();

    logic   valid;
    logic   ready;
    logic   block_start;
    phase_t ext_phase;
    phase_t ext_increment;
    phase_t ext_increment_target;

    modport source (
        output valid, block_start, ext_phase, ext_increment, ext_increment_target,
        input  ready
    );

    modport sink (
        input  valid, block_start, ext_phase, ext_increment, ext_increment_target,
        output ready
    );

endinterface

// ----- rtl/core/mwo_out_if.sv -----
interface mwo_out_if import mwo_pkg::*; ();

    logic    valid;
    logic    ready;
    sample_t sample;

    modport source (
        output valid, sample,
        input  ready
    );

    modport sink (
        input  valid, sample,
        output ready
    );

endinterface

// ----- rtl/core/multi_waveform_oscillator_unit.sv -----
// an accepted item passes through the phase, table and result stages in order
// throughput: one item per cycle while the output is not stalled; the phase accumulator and ramp update
// need no extra stage, and the quarter-wave table is a rom with a registered read
// stalls on the output back up stage by stage, empty stages are filled first
// reset clears phase, index, latched increments and valid bits; block_len_log2 resets to 9
module multi_waveform_oscillator_unit import mwo_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    mwo_in_if.sink                   din,
    mwo_out_if.source                dout,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    // configuration registers
    wave_t      waveform_reg;
    phase_t     phase_increment_reg;
    phase_t     phase_shift_reg;
    logic       use_external_reg;
    logic [3:0] block_len_log2_reg;

    // oscillator state
    phase_t                        phase_acc_reg;
    logic [INDEX_BITS-1:0]         sample_index_reg;
    phase_t                        start_step_reg;
    logic signed [DIFF_BITS-1:0]   step_diff_reg;
    logic signed [RAMP_BITS-1:0]   ramp_acc_reg;

    // pipeline
    logic                     s1_valid_reg;
    phase_t                   s1_phase_reg;
    wave_t                    s1_wave_reg;
    logic                     s2_valid_reg;
    logic [SAMPLE_BITS-1:0]   s2_rom_reg;
    wave_t                    s2_wave_reg;
    logic                     s2_use_max_reg;
    logic                     s2_negate_reg;
    sample_t                  s2_direct_reg;
    logic                     out_valid_reg;
    sample_t                  sample_reg;

    logic cfg_write;
    reg_idx_t cfg_idx;
    logic in_fire;
    logic out_free;
    logic load_out;
    logic s2_ready;
    logic load_s2;
    logic s1_ready;

    // apb register file
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[APB_ADDR_BITS-1:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waveform_reg        <= WAVE_SINE;
            phase_increment_reg <= '0;
            phase_shift_reg     <= '0;
            use_external_reg    <= 1'b0;
            block_len_log2_reg  <= BLOCK_LEN_LOG2_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_WAVEFORM:        waveform_reg        <= pwdata[2:0];
                REG_PHASE_INCREMENT: phase_increment_reg <= pwdata[PHASE_BITS-1:0];
                REG_PHASE_SHIFT:     phase_shift_reg     <= pwdata[PHASE_BITS-1:0];
                REG_USE_EXTERNAL:    use_external_reg    <= pwdata[0];
                REG_BLOCK_LEN_LOG2:  block_len_log2_reg  <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_WAVEFORM:        prdata = APB_DATA_BITS'(waveform_reg);
            REG_PHASE_INCREMENT: prdata = APB_DATA_BITS'(phase_increment_reg);
            REG_PHASE_SHIFT:     prdata = APB_DATA_BITS'(phase_shift_reg);
            REG_USE_EXTERNAL:    prdata = APB_DATA_BITS'(use_external_reg);
            REG_BLOCK_LEN_LOG2:  prdata = APB_DATA_BITS'(block_len_log2_reg);
            default:             prdata = '0;
        endcase
    end

    // handshake chain, each stage moves when the next one is free
    assign out_free  = !out_valid_reg || dout.ready;
    assign load_out  = s2_valid_reg && out_free;
    assign s2_ready  = !s2_valid_reg || load_out;
    assign load_s2   = s1_valid_reg && s2_ready;
    assign s1_ready  = !s1_valid_reg || load_s2;
    assign din.ready = s1_ready;
    assign in_fire   = din.valid && s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= din.valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (out_free)
                out_valid_reg <= s2_valid_reg;
        end
    end

    // block start latching and ramp operands
    logic                          ext_start;
    phase_t                        phase_base;
    phase_t                        start_eff;
    logic signed [DIFF_BITS-1:0]   diff_eff;
    logic [INDEX_BITS-1:0]         index_eff;
    logic signed [RAMP_BITS-1:0]   acc_eff;
    logic [3:0]                    len_log2;
    logic [INDEX_BITS-1:0]         block_len;
    logic signed [RAMP_BITS-1:0]   ramp_full;
    logic signed [RAMP_BITS-1:0]   ramp_prod;
    logic signed [RAMP_BITS-1:0]   ramp_q;
    phase_t                        increment;
    phase_t                        phase_next;
    logic [INDEX_BITS-1:0]         index_next;
    logic signed [RAMP_BITS-1:0]   acc_next;
    logic                          index_open;

    assign ext_start  = din.block_start && use_external_reg;
    assign phase_base = ext_start ? (din.ext_phase + phase_shift_reg) : phase_acc_reg;
    assign start_eff  = ext_start ? din.ext_increment : start_step_reg;
    assign diff_eff   = ext_start
                        ? ($signed({1'b0, din.ext_increment_target})
                           - $signed({1'b0, din.ext_increment}))
                        : step_diff_reg;
    assign index_eff  = din.block_start ? '0 : sample_index_reg;
    assign acc_eff    = din.block_start ? '0 : ramp_acc_reg;
    assign index_open = index_eff < INDEX_MAX;

    // ramp term: floor(diff * min(index, len) / len), len a power of two
    assign len_log2  = (block_len_log2_reg > 4'(MAX_BLOCK_LOG2))
                       ? 4'(MAX_BLOCK_LOG2) : block_len_log2_reg;
    assign block_len = INDEX_BITS'(1) << len_log2;
    assign ramp_full = RAMP_BITS'(diff_eff) <<< len_log2;
    assign ramp_prod = (index_eff >= block_len) ? ramp_full : acc_eff;
    assign ramp_q    = ramp_prod >>> len_log2;

    always_comb
    begin
        if (!use_external_reg)
            increment = phase_increment_reg;
        else if (waveform_reg == WAVE_FALL_SAW)
            increment = start_eff + ramp_q[PHASE_BITS-1:0];
        else
            increment = start_eff;
    end

    assign phase_next = (waveform_reg <= WAVE_FALL_SAW) ? (phase_base + increment) : phase_base;
    assign index_next = index_open ? (index_eff + 1'b1) : index_eff;
    assign acc_next   = index_open ? (acc_eff + RAMP_BITS'(diff_eff)) : acc_eff;

    // oscillator state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg    <= '0;
            sample_index_reg <= '0;
            start_step_reg   <= '0;
            step_diff_reg    <= '0;
            ramp_acc_reg     <= '0;
        end
        else if (in_fire)
        begin
            phase_acc_reg    <= phase_next;
            sample_index_reg <= index_next;
            start_step_reg   <= start_eff;
            step_diff_reg    <= diff_eff;
            ramp_acc_reg     <= acc_next;
        end
    end

    // stage 1: phase of this sample
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_phase_reg <= phase_base;
            s1_wave_reg  <= waveform_reg;
        end
    end

    // waveform shapes from the phase top bits
    logic [1:0]                 sine_quad;
    logic [ROM_ADDR_BITS-1:0]   sine_j;
    logic [ROM_ADDR_BITS-1:0]   rom_addr;
    logic [1:0]                 tri_quad;
    logic [SAMPLE_BITS-2:0]     tri_v;
    logic [SAMPLE_BITS-1:0]     saw_top;
    sample_t                    direct_sample;

    assign sine_quad = s1_phase_reg[PHASE_BITS-1 -: 2];
    assign sine_j    = s1_phase_reg[PHASE_BITS-3 -: ROM_ADDR_BITS];
    assign rom_addr  = sine_quad[0] ? (~sine_j + 1'b1) : sine_j;
    assign tri_quad  = s1_phase_reg[PHASE_BITS-1 -: 2];
    assign tri_v     = s1_phase_reg[PHASE_BITS-3 -: (SAMPLE_BITS - 1)];
    assign saw_top   = s1_phase_reg[PHASE_BITS-1 -: SAMPLE_BITS];

    always_comb
    begin
        case (s1_wave_reg)
            WAVE_SQUARE:
                direct_sample = s1_phase_reg[PHASE_BITS-1] ? SAMPLE_POS_MAX : SAMPLE_NEG_MAX;
            WAVE_TRIANGLE:
            begin
                case (tri_quad)
                    2'd0: direct_sample = sample_t'({1'b0, tri_v});
                    2'd1: direct_sample = (tri_v == '0) ? SAMPLE_POS_MAX
                                          : (SAMPLE_NEG_MAX - sample_t'({1'b0, tri_v}));
                    2'd2: direct_sample = -sample_t'({1'b0, tri_v});
                    default: direct_sample = sample_t'({1'b0, tri_v}) - SAMPLE_NEG_MAX;
                endcase
            end
            WAVE_RISE_SAW:
                direct_sample = sample_t'({~saw_top[SAMPLE_BITS-1], saw_top[SAMPLE_BITS-2:0]});
            WAVE_FALL_SAW:
                direct_sample = (saw_top == '0) ? SAMPLE_POS_MAX
                                : (SAMPLE_NEG_MAX - sample_t'(saw_top));
            default:
                direct_sample = '0;
        endcase
    end

    // stage 2: registered rom read plus the non-sine shapes
    always_ff @(posedge clk)
    begin
        if (load_s2)
        begin
            s2_rom_reg     <= SINE_ROM[rom_addr];
            s2_wave_reg    <= s1_wave_reg;
            s2_use_max_reg <= sine_quad[0] && (sine_j == '0);
            s2_negate_reg  <= sine_quad[1];
            s2_direct_reg  <= direct_sample;
        end
    end

    // result register
    sample_t sine_mag;
    sample_t sample_next;

    assign sine_mag    = s2_use_max_reg ? SAMPLE_POS_MAX : sample_t'(s2_rom_reg);
    assign sample_next = (s2_wave_reg == WAVE_SINE)
                         ? (s2_negate_reg ? -sine_mag : sine_mag)
                         : s2_direct_reg;

    always_ff @(posedge clk)
    begin
        if (load_out)
            sample_reg <= sample_next;
    end

    assign dout.valid  = out_valid_reg;
    assign dout.sample = sample_reg;

`ifndef ASSERT_OFF
    // the index saturates at the longest block
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        sample_index_reg <= INDEX_MAX)
        else $error("sample index past saturation");

    // a block start restarts the index count
    a_block_restart: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && din.block_start |=> sample_index_reg == INDEX_BITS'(1))
        else $error("block start did not restart index");

    // an unknown waveform leaves the phase alone
    a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (waveform_reg > WAVE_FALL_SAW) && !ext_start |=> $stable(phase_acc_reg))
        else $error("phase moved on unknown waveform");
`endif

endmodule
